>>> design/pov_column_sync_defines.svh
// Assertion macros shared by the column tracker RTL.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef POV_COLUMN_SYNC_DEFINES_SVH
`define POV_COLUMN_SYNC_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcs same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcs next-cycle check failed");

`endif

>>> design/pcs_pkg.sv
// Package for the column tracker: widths, reset values, payload structs, helpers.
// Depends on nothing; used by pcs_divider and pov_column_sync.
`timescale 1ns / 1ps

package pcs_pkg;

    // Column count is a power of two; COL_W sets it.
    localparam int COL_W       = 8;
    localparam int NUM_COLUMNS = 1 << COL_W;
    localparam int TIME_W      = 48;
    localparam int PERIOD_W    = 32;
    localparam int DEADLINE_W  = 24;
    localparam int OFFSET_W    = 8;
    localparam int MIN_TURN_W  = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int OUT_COL_W   = 8;
    localparam int DVD_W       = TIME_W + COL_W;
    localparam int CNT_W       = $clog2(DVD_W);
    localparam int SUM_W       = ((COL_W > OFFSET_W) ? COL_W : OFFSET_W) + 1;

    localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = PERIOD_W'(1000000);
    localparam logic [MIN_TURN_W-1:0] MIN_TURN_RESET = MIN_TURN_W'(10000);
    localparam logic [COL_W-1:0]      HALF_TURN      = COL_W'(NUM_COLUMNS / 2);

    typedef enum logic [0:0] {
        CFG_COLUMN_OFFSET = 1'b0,
        CFG_MIN_TURN      = 1'b1
    } cfg_index_t;

    typedef enum logic
    {
        MODE_SAMPLE = 1'b0,
        MODE_EDGE   = 1'b1
    } mode_t;

    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] time_us;
    } item_t;

    typedef struct packed {
        logic [OUT_COL_W-1:0]  column;
        logic [OUT_COL_W-1:0]  opposite_column;
        logic [DEADLINE_W-1:0] col_time_us;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Low eight bits of a column index, zero-extended when the count is narrow.
    function automatic logic [OUT_COL_W-1:0] col_to_out(input logic [COL_W-1:0] c);
        logic [SUM_W-1:0] wide;
        begin
            wide = SUM_W'(c);
            return wide[OUT_COL_W-1:0];
        end
    endfunction

endpackage

>>> design/pov_column_sync.sv
// Top level of the rotor column tracker: control, rotor state and result register.
// Depends on pcs_pkg, pcs_divider and pov_column_sync_defines.svh.
//
// Usage. Items arrive on the item channel (item_valid, item_stall, item) and
// results leave on the result channel (result_valid, result_stall, result).
// A transfer happens at a rising edge where valid is high and stall is low.
// A hall edge item (mode 1) updates the turn period and the edge time when it
// comes more than min_turn_us after the last taken edge; it never yields a
// result and holds item_stall high while the block is in ST_EDGE, after which
// it returns to idle and the next transfer can follow.
// A time sample (mode 0) runs a bit-serial division of elapsed * NUM_COLUMNS by
// the turn period, one dividend bit per cycle. The block passes through ST_LOAD,
// ST_DIV and ST_FINISH with item_stall high; ST_FINISH registers the result
// once the output register is free, and the next transfer can follow after
// the return to idle. A result appears only when the column differs from the
// last one served.
// The result sits in an output register, so a stalled receiver only holds the
// block when a second result is ready before the first has been taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and should be written only while the block is idle.
// Reset clears the state: period 1000000 us, edge time 0, column 0, offset 0
// and min_turn_us 10000.
`timescale 1ns / 1ps
`include "pov_column_sync_defines.svh"

module pov_column_sync (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  pcs_pkg::item_t                 item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output pcs_pkg::result_t               result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  pcs_pkg::cfg_index_t            cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pcs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EDGE   = 5'b00010,
        ST_LOAD   = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration and rotor state.
    logic [OFFSET_W-1:0]   offset_reg;
    logic [MIN_TURN_W-1:0] min_turn_reg;
    logic [TIME_W-1:0]     last_edge_reg, last_edge_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [OUT_COL_W-1:0]  current_col_reg, current_col_next;

    // Captured item.
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] gap_reg;

    // Output register.
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    logic                accept;
    logic                out_free;
    logic [PERIOD_W-1:0] divisor;
    logic [COL_W-1:0]    quotient;
    div_status_t         div_status;
    logic [SUM_W-1:0]    col_sum;
    logic [COL_W-1:0]    col;
    logic [COL_W-1:0]    opp;
    logic [OUT_COL_W-1:0] col8;
    logic [PERIOD_W-1:0] deadline_full;
    logic [DEADLINE_W-1:0] deadline;

    assign accept    = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !result_valid_reg || !result_stall;

    // A zero period cannot arise, but the divider is kept safe from it.
    assign divisor = (period_reg == '0) ? PERIOD_W'(1) : period_reg;

    pcs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_LOAD),
        .dividend ({gap_reg, {COL_W{1'b0}}}),
        .divisor  (divisor),
        .quotient (quotient),
        .status   (div_status)
    );

    // Only the low quotient bits matter: the modulo by the column count is free.
    assign col_sum = SUM_W'(quotient) + SUM_W'(offset_reg);
    assign col     = col_sum[COL_W-1:0];
    assign opp     = col + HALF_TURN;
    assign col8    = col_to_out(col);

    // The period divided by the column count is a plain shift.
    assign deadline_full = period_reg >> COL_W;
    assign deadline = (deadline_full > PERIOD_W'({DEADLINE_W{1'b1}}))
                      ? {DEADLINE_W{1'b1}} : deadline_full[DEADLINE_W-1:0];

    always_comb
    begin
        state_next        = state_reg;
        last_edge_next    = last_edge_reg;
        period_next       = period_reg;
        current_col_next  = current_col_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.mode == MODE_EDGE) ? ST_EDGE : ST_LOAD;
                end
            end
            ST_EDGE:
            begin
                if (gap_reg > TIME_W'(min_turn_reg))
                begin
                    period_next = (gap_reg > TIME_W'({PERIOD_W{1'b1}}))
                                  ? {PERIOD_W{1'b1}} : gap_reg[PERIOD_W-1:0];
                    last_edge_next = time_reg;
                end
                state_next = ST_IDLE;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (col8 == current_col_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    result_next.column          = col8;
                    result_next.opposite_column = col_to_out(opp);
                    result_next.col_time_us     = deadline;
                    result_valid_next           = 1'b1;
                    current_col_next            = col8;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            offset_reg       <= '0;
            min_turn_reg     <= MIN_TURN_RESET;
            last_edge_reg    <= '0;
            period_reg       <= PERIOD_RESET;
            current_col_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            last_edge_reg    <= last_edge_next;
            period_reg       <= period_next;
            current_col_reg  <= current_col_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_COLUMN_OFFSET: offset_reg   <= cfg_data[OFFSET_W-1:0];
                    CFG_MIN_TURN:      min_turn_reg <= cfg_data[MIN_TURN_W-1:0];
                    default:           offset_reg   <= offset_reg;
                endcase
            end
        end
    end

    // Payload registers; the gap is taken modulo 2^48 by the subtract itself.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            time_reg <= item.time_us;
            gap_reg  <= item.time_us - last_edge_reg;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The divider reports completion only while the controller waits for it.
    `PCS_ASSERT_NOW(a_done_in_div, div_status.done, state_reg == ST_DIV)
    // While the controller waits, the divider is either running or just finished.
    `PCS_ASSERT_NOW(a_div_running, state_reg == ST_DIV, div_status.busy || div_status.done)
    // The turn period never reaches zero.
    `PCS_ASSERT_NOW(a_period_nonzero, 1'b1, period_reg != '0)
    // A new result always carries the column that is now recorded as served.
    `PCS_ASSERT_NOW(a_result_matches, $rose(result_valid_reg),
                    result_reg.column == current_col_reg)
    // A result is loaded only at the end of a time sample.
    `PCS_ASSERT_NOW(a_result_from_finish, $rose(result_valid_reg),
                    $past(state_reg) == ST_FINISH)

endmodule

>>> design/pcs_divider.sv
// Bit-serial restoring divider: one dividend bit per cycle, low quotient bits kept.
// Depends on pcs_pkg.
`timescale 1ns / 1ps

module pcs_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pcs_pkg::DVD_W-1:0]    dividend,
    input  logic [pcs_pkg::PERIOD_W-1:0] divisor,
    output logic [pcs_pkg::COL_W-1:0]    quotient,
    output pcs_pkg::div_status_t         status
);
    import pcs_pkg::*;

    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [COL_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;
    logic                fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[COL_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
